[rtl/core/lfu_page_replacement_macros.svh]
// assertion macros for the lfu page replacement block
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lfu check failed");
`define LFU_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lfu check failed");
`else
`define LFU_ASSERT_IMP(label, cond, prop)
`define LFU_ASSERT_NEXT(label, cond, prop)
`endif

`endif

[rtl/core/lfu_pkg.sv]
// shared constants and types for the lfu page replacement block
package lfu_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int USE_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_W      = 5;
    localparam int CFG_RESET  = 16;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [USE_W-1:0]     use_count;
        logic [STAMP_W-1:0]   last_use;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     found_idx;
        logic [USE_W-1:0]     found_cnt;
        logic                 free_found;
        logic [IDX_W-1:0]     free_idx;
        logic [CNT_W-1:0]     occupied;
        logic                 victim_found;
        logic [IDX_W-1:0]     victim_idx;
        logic [PAGE_BITS-1:0] victim_page;
    } scan_res_t;

endpackage

[rtl/core/lfu_ram.sv]
// generic single write port ram with registered read
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lfu_scan.sv]
// per-frame evaluation over one pass: lookup, free slot, occupancy and victim search
`include "lfu_page_replacement_macros.svh"

module lfu_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          eval,
    input  logic [lfu_pkg::IDX_W-1:0]     eval_idx,
    input  logic                          eval_valid,
    input  lfu_pkg::entry_t               entry,
    input  logic [lfu_pkg::PAGE_BITS-1:0] page,
    input  logic [lfu_pkg::STAMP_W-1:0]   stamp,
    output lfu_pkg::scan_res_t            res
);

    lfu_pkg::scan_res_t               res_reg, res_next;
    logic [lfu_pkg::USE_W-1:0]        best_cnt_reg, best_cnt_next;
    logic [lfu_pkg::STAMP_W-1:0]      best_age_reg, best_age_next;
    logic [lfu_pkg::STAMP_W-1:0]      age;
    logic                             take_victim;

    assign age = stamp - entry.last_use;

    assign take_victim = !res_reg.victim_found
                      || (entry.use_count < best_cnt_reg)
                      || ((entry.use_count == best_cnt_reg) && (age > best_age_reg));

    always_comb
    begin
        res_next      = res_reg;
        best_cnt_next = best_cnt_reg;
        best_age_next = best_age_reg;
        if (clear)
        begin
            res_next      = '0;
            best_cnt_next = '0;
            best_age_next = '0;
        end
        else if (eval)
        begin
            if (eval_valid)
            begin
                res_next.occupied = res_reg.occupied + lfu_pkg::CNT_W'(1);
                if (!res_reg.found && (entry.page == page))
                begin
                    res_next.found     = 1'b1;
                    res_next.found_idx = eval_idx;
                    res_next.found_cnt = entry.use_count;
                end
                if (take_victim)
                begin
                    res_next.victim_found = 1'b1;
                    res_next.victim_idx   = eval_idx;
                    res_next.victim_page  = entry.page;
                    best_cnt_next         = entry.use_count;
                    best_age_next         = age;
                end
            end
            else if (!res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = eval_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg      <= '0;
            best_cnt_reg <= '0;
            best_age_reg <= '0;
        end
        else
        begin
            res_reg      <= res_next;
            best_cnt_reg <= best_cnt_next;
            best_age_reg <= best_age_next;
        end
    end

    assign res = res_reg;

    `LFU_ASSERT_NEXT(a_occ_grows, eval && eval_valid && !clear, res_reg.occupied != '0)
    `LFU_ASSERT_IMP(a_found_has_victim, res_reg.found, res_reg.victim_found)
    `LFU_ASSERT_NEXT(a_clear_empty, clear, !res_reg.found && !res_reg.victim_found)

endmodule

[rtl/core/lfu_page_replacement.sv]
// top level of the lfu page replacement block with lru tie break
// each accepted page is scanned over the frame ram in ST_SCAN, then written back in ST_WRITE
// a new page is not accepted until the previous one is written back; in_stall is high meanwhile
// the write-back waits while a previous result is still stalled at the output
// reset clears valid bits, totals, stamp and sets the frame limit to 16; ram is not cleared
`include "lfu_page_replacement_macros.svh"

module lfu_page_replacement (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lfu_pkg::PAGE_BITS-1:0] page,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic                          evicted_valid,
    output logic [lfu_pkg::PAGE_BITS-1:0] evicted_page,
    output logic [lfu_pkg::TOTAL_W-1:0]   hit_total,
    output logic [lfu_pkg::TOTAL_W-1:0]   miss_total
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [lfu_pkg::CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [lfu_pkg::CFG_W-1:0]       cfg_reg;
    logic [lfu_pkg::PAGE_BITS-1:0]   page_reg;
    logic [lfu_pkg::STAMP_W-1:0]     stamp_reg;
    logic [lfu_pkg::TOTAL_W-1:0]     hit_cnt_reg, miss_cnt_reg;
    logic [lfu_pkg::MAX_FRAMES-1:0]  valid_reg;

    logic                            out_valid_reg;
    logic                            hit_reg;
    logic                            evicted_valid_reg;
    logic [lfu_pkg::PAGE_BITS-1:0]   evicted_page_reg;
    logic [lfu_pkg::TOTAL_W-1:0]     hit_total_reg, miss_total_reg;

    logic                            accept;
    logic                            go;
    logic                            ram_we;
    logic [lfu_pkg::IDX_W-1:0]       ram_waddr;
    lfu_pkg::entry_t                 ram_wentry;
    logic [lfu_pkg::ENTRY_W-1:0]     ram_rdata;
    lfu_pkg::entry_t                 rd_entry;
    logic                            eval;
    logic [lfu_pkg::IDX_W-1:0]       eval_idx;
    lfu_pkg::scan_res_t              scan_res;
    logic [lfu_pkg::CNT_W-1:0]       limit;
    logic                            evict;
    logic [lfu_pkg::USE_W-1:0]       cnt_inc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign go       = (state_reg == ST_WRITE) && (!out_valid_reg || !out_stall);
    assign ram_we   = go;
    assign eval     = (state_reg == ST_SCAN) && (scan_cnt_reg != '0);
    assign eval_idx = lfu_pkg::IDX_W'(scan_cnt_reg - lfu_pkg::CNT_W'(1));
    assign rd_entry = lfu_pkg::entry_t'(ram_rdata);

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            limit = lfu_pkg::CNT_W'(1);
        end
        else if (32'(cfg_reg) > 32'(lfu_pkg::MAX_FRAMES))
        begin
            limit = lfu_pkg::CNT_W'(lfu_pkg::MAX_FRAMES);
        end
        else
        begin
            limit = lfu_pkg::CNT_W'(cfg_reg);
        end
    end

    assign evict   = (scan_res.occupied >= limit) || !scan_res.free_found;
    assign cnt_inc = (scan_res.found_cnt == '1) ? scan_res.found_cnt
                                                : scan_res.found_cnt + lfu_pkg::USE_W'(1);

    always_comb
    begin
        ram_wentry.page     = page_reg;
        ram_wentry.last_use = stamp_reg;
        if (scan_res.found)
        begin
            ram_waddr            = scan_res.found_idx;
            ram_wentry.use_count = cnt_inc;
        end
        else
        begin
            ram_waddr            = evict ? scan_res.victim_idx : scan_res.free_idx;
            ram_wentry.use_count = lfu_pkg::USE_W'(1);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + lfu_pkg::CNT_W'(1);
                if (scan_cnt_reg == lfu_pkg::CNT_W'(lfu_pkg::MAX_FRAMES))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            cfg_reg       <= lfu_pkg::CFG_W'(lfu_pkg::CFG_RESET);
            stamp_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (accept)
            begin
                stamp_reg <= stamp_reg + lfu_pkg::STAMP_W'(1);
            end
            if (go)
            begin
                out_valid_reg        <= 1'b1;
                valid_reg[ram_waddr] <= 1'b1;
                if (scan_res.found)
                begin
                    hit_cnt_reg <= hit_cnt_reg + lfu_pkg::TOTAL_W'(1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + lfu_pkg::TOTAL_W'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page;
        end
        if (go)
        begin
            hit_reg           <= scan_res.found;
            evicted_valid_reg <= !scan_res.found && evict;
            evicted_page_reg  <= (!scan_res.found && evict) ? scan_res.victim_page : '0;
            hit_total_reg     <= scan_res.found ? hit_cnt_reg + lfu_pkg::TOTAL_W'(1)
                                                : hit_cnt_reg;
            miss_total_reg    <= scan_res.found ? miss_cnt_reg
                                                : miss_cnt_reg + lfu_pkg::TOTAL_W'(1);
        end
    end

    lfu_ram #(
        .WIDTH (lfu_pkg::ENTRY_W),
        .DEPTH (lfu_pkg::MAX_FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (scan_cnt_reg[lfu_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lfu_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept),
        .eval       (eval),
        .eval_idx   (eval_idx),
        .eval_valid (valid_reg[eval_idx]),
        .entry      (rd_entry),
        .page       (page_reg),
        .stamp      (stamp_reg),
        .res        (scan_res)
    );

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_total     = hit_total_reg;
    assign miss_total    = miss_total_reg;

    `LFU_ASSERT_NEXT(a_accept_scan, accept, state_reg == ST_SCAN && scan_cnt_reg == '0)
    `LFU_ASSERT_NEXT(a_wb_result, ram_we, out_valid_reg && state_reg == ST_IDLE)
    `LFU_ASSERT_IMP(a_evict_has_victim, go && !scan_res.found && evict, scan_res.victim_found)
    `LFU_ASSERT_IMP(a_evict_is_miss, out_valid_reg && evicted_valid_reg, !hit_reg)

endmodule

[test/lfu_scoreboard.sv]
// scoreboard for lfu_page_replacement: tracks the frame store, predicts each result and compares
module lfu_scoreboard
    import lfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [PAGE_BITS-1:0] page,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 hit,
    input  logic                 evicted_valid,
    input  logic [PAGE_BITS-1:0] evicted_page,
    input  logic [TOTAL_W-1:0]   hit_total,
    input  logic [TOTAL_W-1:0]   miss_total,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [TOTAL_W-1:0]   hit_total;
        logic [TOTAL_W-1:0]   miss_total;
    } page_outcome_t;

    logic                 resident    [MAX_FRAMES];
    logic [PAGE_BITS-1:0] frame_pg    [MAX_FRAMES];
    logic [USE_W-1:0]     use_cnt     [MAX_FRAMES];
    logic [STAMP_W-1:0]   touched_at  [MAX_FRAMES];
    logic [STAMP_W-1:0]   clock_stamp;
    logic [TOTAL_W-1:0]   hits_so_far;
    logic [TOTAL_W-1:0]   misses_so_far;
    logic [CFG_W-1:0]     frame_limit_reg;

    page_outcome_t outcome_queue [$];

    function automatic page_outcome_t reference_page(input logic [PAGE_BITS-1:0] pg);
        page_outcome_t      r;
        int                 found;
        int                 free_slot;
        int                 victim;
        int                 slot;
        int unsigned        occupied;
        int unsigned        lim;
        logic [USE_W-1:0]   best_cnt;
        logic [STAMP_W-1:0] best_age;
        logic [STAMP_W-1:0] age;
        r         = '0;
        found     = -1;
        free_slot = -1;
        victim    = -1;
        occupied  = 0;
        best_cnt  = '0;
        best_age  = '0;
        clock_stamp = clock_stamp + 1;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (resident[i])
            begin
                occupied++;
                if (found < 0 && frame_pg[i] == pg)
                    found = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            hits_so_far = hits_so_far + 1;
            if (use_cnt[found] != '1)
                use_cnt[found] = use_cnt[found] + 1;
            touched_at[found] = clock_stamp;
        end
        else
        begin
            misses_so_far = misses_so_far + 1;
            lim = 32'(frame_limit_reg);
            if (lim == 0)
                lim = 1;
            if (lim > MAX_FRAMES)
                lim = MAX_FRAMES;
            if (occupied >= lim || free_slot < 0)
            begin
                for (int i = 0; i < MAX_FRAMES; i++)
                begin
                    if (resident[i])
                    begin
                        age = clock_stamp - touched_at[i];
                        if (victim < 0 || use_cnt[i] < best_cnt ||
                            (use_cnt[i] == best_cnt && age > best_age))
                        begin
                            victim   = i;
                            best_cnt = use_cnt[i];
                            best_age = age;
                        end
                    end
                end
            end
            if (victim >= 0)
            begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_pg[victim];
                slot = victim;
            end
            else
                slot = free_slot;
            resident[slot]   = 1'b1;
            frame_pg[slot]   = pg;
            use_cnt[slot]    = 1;
            touched_at[slot] = clock_stamp;
        end
        r.hit_total  = hits_so_far;
        r.miss_total = misses_so_far;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        page_outcome_t want;
        page_outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
                resident[i] = 1'b0;
            clock_stamp     = '0;
            hits_so_far     = '0;
            misses_so_far   = '0;
            frame_limit_reg = CFG_W'(CFG_RESET);
            outcome_queue.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                frame_limit_reg = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                got = '{hit, evicted_valid, evicted_page, hit_total, miss_total};
                if (outcome_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: unexpected result hit=%0b ev=%0b ev_page=%h",
                                  " hits=%0d misses=%0d"},
                                 $time, got.hit, got.evicted_valid, got.evicted_page,
                                 got.hit_total, got.miss_total);
                end
                else
                begin
                    want = outcome_queue.pop_front();
                    if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
                        got.evicted_page !== want.evicted_page ||
                        got.hit_total !== want.hit_total || got.miss_total !== want.miss_total)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display({"%0t: expected hit=%0b ev=%0b ev_page=%h",
                                      " hits=%0d misses=%0d"},
                                     $time, want.hit, want.evicted_valid, want.evicted_page,
                                     want.hit_total, want.miss_total);
                            $display({"%0t:   actual hit=%0b ev=%0b ev_page=%h",
                                      " hits=%0d misses=%0d"},
                                     $time, got.hit, got.evicted_valid, got.evicted_page,
                                     got.hit_total, got.miss_total);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                outcome_queue.insert(outcome_queue.size(), reference_page(page));
            pending = outcome_queue.size();
        end
    end

endmodule

[test/tb_top.sv]
// top of the lfu_page_replacement testbench: clock, reset, page stimulus, output stalls, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 60;
    localparam int PHASES        = 8;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [PAGE_BITS-1:0] page          = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   miss_total;
    int                   errors;
    int                   pending;

    int                   cycle_count   = 0;
    int                   burst_left    = 0;
    bit                   hold_request  = 1'b0;
    bit                   hold_done     = 1'b0;
    logic [PAGE_BITS-1:0] hot_pages [24];
    logic [CFG_W-1:0]     limit_plan [PHASES] =
        '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd9};

    lfu_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total),
        .miss_total    (miss_total)
    );

    lfu_scoreboard scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .hit_total     (hit_total),
        .miss_total    (miss_total),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic offer_page(input logic [PAGE_BITS-1:0] pg);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        page     <= pg;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic drain_items();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_limit(input logic [CFG_W-1:0] v);
        drain_items();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        burst_left = 0;
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int seg;
        int mode;
        forever
        begin
            if (hold_request && !hold_done)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            seg  = $urandom_range(10, 120);
            mode = $urandom_range(0, 3);
            repeat (seg)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    initial
    begin
        int psize;
        hot_pages[0] = '0;
        hot_pages[1] = '1;
        for (int i = 2; i < 24; i++)
            hot_pages[i] = PAGE_BITS'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill with the extreme pages, repeat hits, free frames
        offer_page(16'h0000);
        offer_page(16'hFFFF);
        offer_page(16'h0000);
        offer_page(16'h0000);
        offer_page(16'hFFFF);
        offer_page(16'hAAAA);
        offer_page(16'h5555);
        // limit below occupancy: lowest count goes, oldest among equals
        set_frame_limit(5'd3);
        offer_page(16'h1234);
        offer_page(16'h5555);
        offer_page(16'h4321);
        offer_page(16'h4321);
        offer_page(16'h0F0F);
        offer_page(16'h0000);
        // zero limit acts as one frame
        set_frame_limit(5'd0);
        offer_page(16'h7777);
        offer_page(16'h0000);
        offer_page(16'h8001);
        // limit above the frame count saturates
        set_frame_limit(5'd31);
        for (int i = 0; i < 6; i++)
            offer_page(16'h0100 + 16'(i));
        offer_page(16'h0100);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_frame_limit(limit_plan[ph]);
            psize = $urandom_range(3, 24);
            if (ph == 2)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    offer_page(PAGE_BITS'($urandom));
                else
                    offer_page(hot_pages[$urandom_range(0, $urandom_range(0, psize - 1))]);
            end
        end

        drain_items();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
